@@ rtl/core/pcx_rle_pkg.sv @@
// shared types and constants of the pcx run-length pixel decoder
package pcx_rle_pkg;

    typedef enum logic [1:0] {
        OP_DATA      = 2'd0,
        OP_PAL_WRITE = 2'd1,
        OP_NEW_IMAGE = 2'd2,
        OP_NONE      = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_COLOR_MODE   = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PLANE_BLUE  = 2'd0,
        PLANE_GREEN = 2'd1,
        PLANE_RED   = 2'd2,
        PLANE_NONE  = 2'd3
    } plane_t;

    localparam logic [7:0]  RUN_MARK   = 8'hBF;
    localparam logic [5:0]  COUNT_MASK = 6'h3F;
    localparam logic [7:0]  ALPHA_ON   = 8'hFF;
    localparam logic [31:0] MAX_PIXELS = 32'd4194304;

    localparam logic STATUS_PIXEL    = 1'b0;
    localparam logic STATUS_TOO_BIG  = 1'b1;

endpackage

@@ rtl/core/pcx_rle_pixel_decoder_unit.sv @@
// pcx run-length pixel decoder top level with palette memory
//
// input channel (s_*): one transaction carries an opcode: a coded data byte,
// a palette entry write or a start of a new image. results leave on the m_*
// channel as pixels with their plane, column and row, or as one status
// result when a new image is larger than the pixel limit.
// the palette is a 256 x 24 synchronous memory; the lookup address is read
// when the value byte is accepted and the data is held for the whole run.
// a literal or run value byte enters the emit state, which loads one pixel
// per cycle into the output register while that register is free; s_ready
// stays low for the whole run. palette writes, run markers and ignored
// bytes stay idle. a new image registers the size product, then compares it.
// a single output register holds the next result, so a stalled m_ready
// stops the run expansion and with it the input channel.
// reset clears the configuration, run state and position; the palette
// content is undefined until written.
module pcx_rle_pixel_decoder_unit
    import pcx_rle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_data_byte,
    input  logic [7:0]  s_pal_index,
    input  logic [23:0] s_pal_color,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pixel_word,
    output logic [1:0]  m_plane,
    output logic [15:0] m_column,
    output logic [15:0] m_row,
    output logic        m_run_last,
    output logic        m_image_done,
    output logic        m_status
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t      state_reg, state_next;

    logic        color_mode_reg;
    logic [15:0] image_width_reg;
    logic [15:0] image_height_reg;

    logic [23:0] pal_mem [256];
    logic [23:0] pal_rd_reg;

    logic        await_reg, await_next;
    logic [5:0]  pending_reg, pending_next;
    logic [15:0] column_reg, column_next;
    logic [15:0] row_reg, row_next;
    logic [1:0]  plane_reg, plane_next;
    logic        complete_reg, complete_next;
    logic [5:0]  reps_reg, reps_next;
    logic [7:0]  value_reg;
    logic [31:0] area_reg;

    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_pixel_word_reg;
    logic [1:0]  m_plane_reg;
    logic [15:0] m_column_reg;
    logic [15:0] m_row_reg;
    logic        m_run_last_reg;
    logic        m_image_done_reg;
    logic        m_status_reg;

    logic        accept;
    logic        slot_free;
    logic        load_pixel;
    logic        load_status;
    logic [15:0] eff_width;
    logic [15:0] eff_height;
    logic        col_wrap;
    logic        row_end;
    logic        img_end;
    logic        value_byte;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign slot_free  = !m_valid_reg || m_ready;
    assign eff_width  = (image_width_reg == 16'd0) ? 16'd1 : image_width_reg;
    assign eff_height = (image_height_reg == 16'd0) ? 16'd1 : image_height_reg;
    assign value_byte = accept && (s_opcode == OP_DATA) && !complete_reg && await_reg;

    // position step for the pixel leaving in this cycle
    assign col_wrap = ({1'b0, column_reg} + 17'd1) >= {1'b0, eff_width};
    assign row_end  = col_wrap && !(color_mode_reg && (plane_reg != PLANE_BLUE));
    assign img_end  = row_end && (({1'b0, row_reg} + 17'd1) >= {1'b0, eff_height});

    assign load_pixel  = (state_reg == ST_EMIT) && slot_free;
    assign load_status = (state_reg == ST_CHECK) && slot_free && (area_reg > MAX_PIXELS);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_mode_reg   <= 1'b0;
            image_width_reg  <= 16'd1;
            image_height_reg <= 16'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_COLOR_MODE:   color_mode_reg   <= cfg_wdata[0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // palette memory
    always_ff @(posedge aclk) begin
        if (accept && (s_opcode == OP_PAL_WRITE)) begin
            pal_mem[s_pal_index] <= s_pal_color;
        end
        if (value_byte || (accept && (s_opcode == OP_DATA))) begin
            pal_rd_reg <= pal_mem[s_data_byte];
        end
    end

    always_comb begin
        state_next    = state_reg;
        await_next    = await_reg;
        pending_next  = pending_reg;
        column_next   = column_reg;
        row_next      = row_reg;
        plane_next    = plane_reg;
        complete_next = complete_reg;
        reps_next     = reps_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_opcode)
                        OP_NEW_IMAGE: begin
                            await_next    = 1'b0;
                            pending_next  = 6'd0;
                            column_next   = 16'd0;
                            row_next      = 16'd0;
                            plane_next    = PLANE_RED;
                            complete_next = 1'b0;
                            state_next    = ST_CHECK;
                        end
                        OP_DATA: begin
                            if (!complete_reg) begin
                                if (await_reg) begin
                                    reps_next    = (pending_reg == 6'd0) ? 6'd1 : pending_reg;
                                    await_next   = 1'b0;
                                    pending_next = 6'd0;
                                    state_next   = ST_EMIT;
                                end else if (s_data_byte > RUN_MARK) begin
                                    pending_next = s_data_byte[5:0] & COUNT_MASK;
                                    await_next   = 1'b1;
                                end else begin
                                    reps_next  = 6'd1;
                                    state_next = ST_EMIT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CHECK: begin
                if (area_reg > MAX_PIXELS) begin
                    complete_next = 1'b1;
                    if (slot_free) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    if (col_wrap) begin
                        column_next = 16'd0;
                        if (row_end) begin
                            plane_next = PLANE_RED;
                        end else begin
                            plane_next = plane_reg - 2'd1;
                        end
                    end else begin
                        column_next = column_reg + 16'd1;
                    end
                    if (img_end) begin
                        complete_next = 1'b1;
                    end else if (row_end) begin
                        row_next = row_reg + 16'd1;
                    end
                    reps_next = reps_reg - 6'd1;
                    if (img_end || (reps_reg == 6'd1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_pixel || load_status) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            await_reg    <= 1'b0;
            pending_reg  <= 6'd0;
            column_reg   <= 16'd0;
            row_reg      <= 16'd0;
            plane_reg    <= PLANE_RED;
            complete_reg <= 1'b0;
            reps_reg     <= 6'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            await_reg    <= await_next;
            pending_reg  <= pending_next;
            column_reg   <= column_next;
            row_reg      <= row_next;
            plane_reg    <= plane_next;
            complete_reg <= complete_next;
            reps_reg     <= reps_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            value_reg <= s_data_byte;
            area_reg  <= {16'd0, eff_width} * {16'd0, eff_height};
        end
        if (load_pixel) begin
            if (color_mode_reg) begin
                m_pixel_word_reg <= {24'd0, value_reg};
                m_plane_reg      <= plane_reg;
            end else begin
                m_pixel_word_reg <= {ALPHA_ON, pal_rd_reg};
                m_plane_reg      <= PLANE_BLUE;
            end
            m_column_reg     <= column_reg;
            m_row_reg        <= row_reg;
            m_run_last_reg   <= img_end || (reps_reg == 6'd1);
            m_image_done_reg <= img_end;
            m_status_reg     <= STATUS_PIXEL;
        end else if (load_status) begin
            m_pixel_word_reg <= 32'd0;
            m_plane_reg      <= PLANE_BLUE;
            m_column_reg     <= 16'd0;
            m_row_reg        <= 16'd0;
            m_run_last_reg   <= 1'b1;
            m_image_done_reg <= 1'b0;
            m_status_reg     <= STATUS_TOO_BIG;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_word = m_pixel_word_reg;
    assign m_plane      = m_plane_reg;
    assign m_column     = m_column_reg;
    assign m_row        = m_row_reg;
    assign m_run_last   = m_run_last_reg;
    assign m_image_done = m_image_done_reg;
    assign m_status     = m_status_reg;

    a_plane_range: assert property (@(posedge aclk) disable iff (!aresetn)
        plane_reg != PLANE_NONE)
        else $error("plane counter out of range");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_image_done_reg) |-> m_run_last_reg)
        else $error("image completion without run end");

    a_run_end_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_IDLE) && ($past(state_reg) == ST_EMIT))
            |-> (m_valid_reg && m_run_last_reg))
        else $error("run finished without a last transaction");

    a_count_needs_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        !await_reg |-> (pending_reg == 6'd0))
        else $error("run count held outside value wait");

endmodule
